// ----- src/tbs_pkg.sv -----
package tbs_pkg;

    // Width of one text code unit and depth of the held-back tail.
    localparam int UNIT_BITS  = 16;
    localparam int HELD_DEPTH = 11;
    localparam int CNT_BITS   = 4;

    typedef logic [UNIT_BITS-1:0] t_unit;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef struct packed {
        t_unit code_unit;
        logic  end_of_stream;
    } t_in_word;

    typedef struct packed {
        t_unit out_unit;
        logic  is_indicator;
        logic  in_thinking;
        logic  last;
    } t_out_word;

    // What the datapath wants done with the word it is offered.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_OPEN,
        ACT_FLUSH
    } t_act;

    typedef struct packed {
        t_act act;
        t_cnt emit_len;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic take;
        logic load_ind;
        logic load_unit;
        t_cnt rd_idx;
        logic last;
    } t_cmd;

    localparam logic KIND_THINK  = 1'b0;
    localparam logic KIND_REASON = 1'b1;

    // Index of the final character of each tag.
    localparam t_cnt OPEN_THINK_LAST   = 4'd6;
    localparam t_cnt OPEN_REASON_LAST  = 4'd10;
    localparam t_cnt CLOSE_THINK_LAST  = 4'd7;
    localparam t_cnt CLOSE_REASON_LAST = 4'd11;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam t_unit UNIT_KELVIN = 16'h212A;
    localparam t_unit UNIT_LONG_S = 16'h017F;

    // Case folding: ASCII capitals, the Kelvin sign and the long s.
    function automatic t_unit fold_unit(input t_unit u);
        t_unit f;
        if (u >= t_unit'(8'h41) && u <= t_unit'(8'h5A)) begin
            f = u + t_unit'(8'd32);
        end else if (u == UNIT_KELVIN) begin
            f = t_unit'(8'h6B);
        end else if (u == UNIT_LONG_S) begin
            f = t_unit'(8'h73);
        end else begin
            f = u;
        end
        return f;
    endfunction

    function automatic logic [7:0] name_ch(input logic kind, input t_cnt j);
        logic [7:0] c;
        c = 8'h00;
        if (kind == KIND_THINK) begin
            case (j)
                4'd0:    c = "t";
                4'd1:    c = "h";
                4'd2:    c = "i";
                4'd3:    c = "n";
                4'd4:    c = "k";
                default: c = 8'h00;
            endcase
        end else begin
            case (j)
                4'd0:    c = "r";
                4'd1:    c = "e";
                4'd2:    c = "a";
                4'd3:    c = "s";
                4'd4:    c = "o";
                4'd5:    c = "n";
                4'd6:    c = "i";
                4'd7:    c = "n";
                4'd8:    c = "g";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // Character idx of an open tag or, with is_close set, of a close tag.
    function automatic logic [7:0] tag_ch(input logic is_close, input logic kind,
                                          input t_cnt idx);
        t_cnt       j;
        t_cnt       nlen;
        logic [7:0] c;
        nlen = (kind == KIND_REASON) ? 4'd9 : 4'd5;
        j    = idx - 4'd1 - {3'b000, is_close};
        if (idx == 4'd0) begin
            c = CH_LT;
        end else if (is_close && idx == 4'd1) begin
            c = CH_SLASH;
        end else if (j == nlen) begin
            c = CH_GT;
        end else begin
            c = name_ch(kind, j);
        end
        return c;
    endfunction

endpackage

// ----- src/tag_block_stripper.sv -----
// Channel   Direction   Handshake                  Word
// input     in          i_in_valid / o_in_stall    i_in_word  (code_unit, end_of_stream)
// output    out         o_out_valid / i_out_stall  o_out_word (out_unit, is_indicator,
//                                                              in_thinking, last)
//
// A word that produces no output, or only the block-open indicator, needs no drain.
// A word that releases k held or passed-through units (k up to 11) starts a drain, in
// which the controller sends one unit per cycle, except while the output is stalled,
// through the single output register. Reset is synchronous and active low; it leaves
// the block outside any stripped block with an empty held tail. Input is stalled while
// units are being drained and whenever the output register is full and stalled itself.
module tag_block_stripper
    import tbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // The controller sequences the release of held text, while the datapath
    // tracks how far the recent text matches an open or close tag. Because
    // every tag begins with the only opening bracket it contains, the held
    // tail is always a plain prefix of one tag, so a mismatch either empties
    // the tail or restarts it with the new bracket.
    t_status w_status;
    t_cmd    w_cmd;

    tbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // An indicator always closes out the results of its word and marks
    // the stream as inside a block.
    a_ind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.is_indicator |-> o_out_word.last && o_out_word.in_thinking)
        else $error("indicator word without last or in_thinking");

    // Draining held units and taking a new word never happen together.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.take && w_cmd.load_unit))
        else $error("new word taken while held units drain");

    // Once a word with units to release is taken, the input stalls next cycle.
    a_flush_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.take && w_status.act == ACT_FLUSH && w_status.emit_len != '0 |=> o_in_stall)
        else $error("input not stalled while releasing held units");

    // Passed-through text is never flagged as inside a block.
    a_text_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_unit |=> o_out_valid && !o_out_word.in_thinking && !o_out_word.is_indicator)
        else $error("released unit carries block flags");

endmodule

// ----- src/tbs_ctrl.sv -----
module tbs_ctrl
    import tbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_cnt   r_idx;
    t_cnt   r_len;

    logic w_accept;
    logic w_last;

    // A word is only taken when the output register can receive an indicator.
    assign w_accept   = i_in_valid && (r_state == S_IDLE) && i_status.out_free;
    assign o_in_stall = !((r_state == S_IDLE) && i_status.out_free);
    assign w_last     = (r_idx == r_len - 4'd1);

    assign o_cmd.take      = w_accept;
    assign o_cmd.load_ind  = w_accept && (i_status.act == ACT_OPEN);
    assign o_cmd.load_unit = (r_state == S_EMIT) && i_status.out_free;
    assign o_cmd.rd_idx    = r_idx;
    assign o_cmd.last      = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_len   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_status.act == ACT_FLUSH && i_status.emit_len != '0) begin
                        r_state <= S_EMIT;
                        r_idx   <= '0;
                        r_len   <= i_status.emit_len;
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/tbs_datapath.sv -----
module tbs_datapath
    import tbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    // Match state.
    logic  r_inside;
    logic  r_kind;
    t_cnt  r_count;
    logic  r_pt;
    logic  r_pr;

    // Held-back tail and the unit that broke a partial match.
    t_unit r_held [HELD_DEPTH];
    t_unit r_cur;
    t_cnt  r_base;

    logic      r_out_valid;
    t_out_word r_out_word;

    logic  n_inside;
    logic  n_kind;
    t_cnt  n_count;
    logic  n_pt;
    logic  n_pr;

    t_unit w_u;
    t_unit w_fu;
    logic  w_lt;
    logic  w_m_t;
    logic  w_m_r;
    logic  w_m_c;
    t_cnt  w_c_last;
    logic  w_wr_en;
    t_cnt  w_wr_idx;
    t_act  w_act;
    t_cnt  w_len;
    logic  w_out_free;
    t_unit w_rd_unit;

    assign w_u      = i_in_word.code_unit;
    assign w_fu     = fold_unit(w_u);
    assign w_lt     = (w_u == t_unit'(CH_LT));
    assign w_m_t    = r_pt && (w_fu == t_unit'(tag_ch(1'b0, KIND_THINK, r_count)));
    assign w_m_r    = r_pr && (w_fu == t_unit'(tag_ch(1'b0, KIND_REASON, r_count)));
    assign w_m_c    = (w_fu == t_unit'(tag_ch(1'b1, r_kind, r_count)));
    assign w_c_last = (r_kind == KIND_REASON) ? CLOSE_REASON_LAST : CLOSE_THINK_LAST;

    always_comb begin
        n_inside = r_inside;
        n_kind   = r_kind;
        n_count  = r_count;
        n_pt     = r_pt;
        n_pr     = r_pr;
        w_act    = ACT_NONE;
        w_len    = '0;
        w_wr_en  = 1'b0;
        w_wr_idx = r_count;
        if (i_in_word.end_of_stream) begin
            n_count = '0;
            n_pt    = 1'b1;
            n_pr    = 1'b1;
            if (!r_inside) begin
                w_act = ACT_FLUSH;
                w_len = r_count;
            end
        end else if (!r_inside) begin
            if (w_m_t && r_count == OPEN_THINK_LAST) begin
                w_act    = ACT_OPEN;
                n_inside = 1'b1;
                n_kind   = KIND_THINK;
                n_count  = '0;
                n_pt     = 1'b1;
                n_pr     = 1'b1;
            end else if (w_m_r && r_count == OPEN_REASON_LAST) begin
                w_act    = ACT_OPEN;
                n_inside = 1'b1;
                n_kind   = KIND_REASON;
                n_count  = '0;
                n_pt     = 1'b1;
                n_pr     = 1'b1;
            end else if (w_m_t || w_m_r) begin
                n_count = r_count + 4'd1;
                n_pt    = w_m_t;
                n_pr    = w_m_r;
                w_wr_en = 1'b1;
            end else begin
                // The held tail goes out, followed by the new unit unless it
                // can start a fresh tag. Slot zero of a tail always holds the
                // opening bracket, so rewriting it with one loses nothing.
                w_act    = ACT_FLUSH;
                w_len    = r_count + {3'b000, !w_lt};
                n_count  = {3'b000, w_lt};
                n_pt     = 1'b1;
                n_pr     = 1'b1;
                w_wr_en  = w_lt;
                w_wr_idx = '0;
            end
        end else begin
            if (w_m_c && r_count == w_c_last) begin
                n_inside = 1'b0;
                n_kind   = KIND_THINK;
                n_count  = '0;
            end else if (w_m_c) begin
                n_count = r_count + 4'd1;
            end else begin
                n_count = {3'b000, w_lt};
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_status.act      = w_act;
    assign o_status.emit_len = w_len;
    assign o_status.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_kind   <= KIND_THINK;
            r_count  <= '0;
            r_pt     <= 1'b1;
            r_pr     <= 1'b1;
        end else if (i_cmd.take) begin
            r_inside <= n_inside;
            r_kind   <= n_kind;
            r_count  <= n_count;
            r_pt     <= n_pt;
            r_pr     <= n_pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cur  <= w_u;
            r_base <= r_count;
            if (w_wr_en) begin
                r_held[w_wr_idx] <= w_u;
            end
        end
    end

    assign w_rd_unit = (i_cmd.rd_idx == r_base) ? r_cur : r_held[i_cmd.rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_ind || i_cmd.load_unit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ind) begin
            r_out_word.out_unit     <= '0;
            r_out_word.is_indicator <= 1'b1;
            r_out_word.in_thinking  <= 1'b1;
            r_out_word.last         <= 1'b1;
        end else if (i_cmd.load_unit) begin
            r_out_word.out_unit     <= w_rd_unit;
            r_out_word.is_indicator <= 1'b0;
            r_out_word.in_thinking  <= 1'b0;
            r_out_word.last         <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- tb/sv/tbs_stream_checker.sv -----
`timescale 1ns / 1ps
module tbs_stream_checker
    import tbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    // Predicted copy of the stripper state.
    logic      inside_blk = 1'b0;
    logic      blk_kind = KIND_THINK;
    t_unit     held_tail [HELD_DEPTH];
    int        held_len = 0;
    t_unit     window [HELD_DEPTH+1];
    t_out_word expected_words [$];
    t_out_word want;
    int        fails = 0;

    function automatic t_unit fold_case(input t_unit u);
        if (u >= 16'h0041 && u <= 16'h005A) return u | 16'h0020;
        if (u == UNIT_KELVIN) return 16'h006B;
        if (u == UNIT_LONG_S) return 16'h0073;
        return u;
    endfunction

    function automatic string tag_text(input logic closing, input logic kind);
        string s;
        string name;
        name = (kind == KIND_REASON) ? "reasoning" : "think";
        s = "<";
        if (closing) s = {s, "/"};
        s = {s, name, ">"};
        return s;
    endfunction

    // Does window[start +: len] match the first len characters of the tag?
    function automatic logic tag_prefix(input int start, input int len, input string tag);
        logic ok;
        ok = (len <= tag.len());
        for (int i = 0; ok && i < len; i++) begin
            if (fold_case(window[start+i]) != t_unit'(tag[i])) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic ends_with(input int n, input string tag);
        return (n >= tag.len()) && tag_prefix(n - tag.len(), tag.len(), tag);
    endfunction

    function automatic t_out_word make_word(input t_unit u, input logic ind);
        t_out_word r;
        r.out_unit     = u;
        r.is_indicator = ind;
        r.in_thinking  = ind;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic keep_tail(input int from, input int n);
        held_len = 0;
        for (int k = from; k < n && held_len < HELD_DEPTH; k++) begin
            held_tail[held_len] = window[k];
            held_len++;
        end
    endtask

    task automatic predict(input t_in_word w);
        t_out_word res [$];
        t_out_word final_w;
        string     think_open;
        string     reason_open;
        string     shut_tag;
        int        n;
        int        tail;
        int        open_len;
        logic      hit;
        logic      hit_kind;
        think_open  = tag_text(1'b0, KIND_THINK);
        reason_open = tag_text(1'b0, KIND_REASON);
        n = held_len;
        tail = 0;
        hit_kind = KIND_THINK;
        for (int k = 0; k < n; k++) window[k] = held_tail[k];
        if (w.end_of_stream) begin
            if (!inside_blk) begin
                for (int k = 0; k < n; k++) res.push_back(make_word(window[k], 1'b0));
            end
            held_len = 0;
        end else begin
            window[n] = w.code_unit;
            n++;
            if (!inside_blk) begin
                hit = 1'b1;
                if (ends_with(n, think_open)) begin
                    hit_kind = KIND_THINK;
                end else if (ends_with(n, reason_open)) begin
                    hit_kind = KIND_REASON;
                end else begin
                    hit = 1'b0;
                end
                if (hit) begin
                    open_len = (hit_kind == KIND_REASON) ? reason_open.len() : think_open.len();
                    for (int k = 0; k < n - open_len; k++) begin
                        res.push_back(make_word(window[k], 1'b0));
                    end
                    res.push_back(make_word('0, 1'b1));
                    inside_blk = 1'b1;
                    blk_kind   = hit_kind;
                    held_len   = 0;
                end else begin
                    for (int len = (n < HELD_DEPTH) ? n : HELD_DEPTH;
                         len >= 1 && tail == 0; len--) begin
                        if (tag_prefix(n - len, len, think_open) ||
                            tag_prefix(n - len, len, reason_open)) tail = len;
                    end
                    for (int k = 0; k < n - tail; k++) begin
                        res.push_back(make_word(window[k], 1'b0));
                    end
                    keep_tail(n - tail, n);
                end
            end else begin
                shut_tag = tag_text(1'b1, blk_kind);
                if (ends_with(n, shut_tag)) begin
                    inside_blk = 1'b0;
                    blk_kind   = KIND_THINK;
                    held_len   = 0;
                end else begin
                    for (int len = (n < shut_tag.len()) ? n : shut_tag.len();
                         len >= 1 && tail == 0; len--) begin
                        if (tag_prefix(n - len, len, shut_tag)) tail = len;
                    end
                    keep_tail(n - tail, n);
                end
            end
        end
        if (res.size() > 0) begin
            final_w = res.pop_back();
            final_w.last = 1'b1;
            res.push_back(final_w);
        end
        foreach (res[k]) expected_words.push_back(res[k]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inside_blk = 1'b0;
            blk_kind   = KIND_THINK;
            held_len   = 0;
            fails      = 0;
            expected_words.delete();
        end else begin
            // Predict before comparing so that an output word of this very edge
            // still finds its expectation in order.
            if (i_in_valid && !i_in_stall) predict(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected output word: out_unit %h is_indicator %b last %b",
                           i_out_word.out_unit, i_out_word.is_indicator, i_out_word.last);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (want.out_unit !== i_out_word.out_unit) begin
                        $error("out_unit: expected %h, actual %h",
                               want.out_unit, i_out_word.out_unit);
                        fails++;
                    end
                    if (want.is_indicator !== i_out_word.is_indicator) begin
                        $error("is_indicator: expected %b, actual %b",
                               want.is_indicator, i_out_word.is_indicator);
                        fails++;
                    end
                    if (want.in_thinking !== i_out_word.in_thinking) begin
                        $error("in_thinking: expected %b, actual %b",
                               want.in_thinking, i_out_word.in_thinking);
                        fails++;
                    end
                    if (want.last !== i_out_word.last) begin
                        $error("last: expected %b, actual %b", want.last, i_out_word.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top
    import tbs_pkg::*;
();

    // Receiver behavior, held for a random stretch of cycles before it changes.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_HEAVY
    } t_rx_mode;

    // Kinds of text fragment that the random part strings together.
    typedef enum logic [2:0] {
        SEG_BLOCK,
        SEG_TEXT,
        SEG_PARTIAL,
        SEG_NOISE,
        SEG_FLUSH
    } t_seg;

    localparam int RANDOM_WORDS = 320;
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    int        fail_count;
    int        pending;
    int        sent = 0;
    int        burst_left = 0;
    t_rx_mode  rx_mode = RX_FREE;
    int        rx_hold = 0;

    always #5 clk = ~clk;

    tag_block_stripper i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    tbs_stream_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The receiver switches between flowing freely, light, even and heavy
    // back-pressure, so that stalls land on every phase of a drain.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (rx_hold == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_hold <= $urandom_range(16, 96);
            end else begin
                rx_hold <= rx_hold - 1;
            end
            case (rx_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_COIN:   out_stall <= ($urandom_range(0, 1) == 0);
                RX_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
                default:   out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Offers one word and returns at the edge where it is taken. The sender
    // works in bursts; valid may drop between bursts, and about two bursts out of
    // three follow on with no gap at all.
    task automatic send_word(input logic eos, input t_unit u);
        t_in_word w;
        int       gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        w.code_unit     = u;
        w.end_of_stream = eos;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        burst_left--;
        sent++;
    endtask

    task automatic send_unit(input t_unit u);
        send_word(1'b0, u);
    endtask

    // The code unit of an end-of-stream word is ignored, so it carries noise.
    task automatic send_eos();
        send_word(1'b1, t_unit'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_unit(t_unit'(s[i]));
    endtask

    function automatic string tag_name(input logic kind);
        return (kind == KIND_REASON) ? "reasoning" : "think";
    endfunction

    // Returns a letter of a tag name in either case, and now and then the
    // Kelvin sign or the long s where they fold onto the letter.
    function automatic t_unit vary_case(input byte c);
        t_unit u;
        u = t_unit'(c);
        if (c == "k" && $urandom_range(0, 5) == 0) begin
            u = UNIT_KELVIN;
        end else if (c == "s" && $urandom_range(0, 5) == 0) begin
            u = UNIT_LONG_S;
        end else if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 0) begin
            u = u - 16'd32;
        end
        return u;
    endfunction

    // Text that is mostly printable but leans heavily on tag characters, so
    // that the hold-back logic keeps seeing near misses.
    function automatic t_unit filler_unit();
        string letters;
        t_unit u;
        letters = "thinkreasog";
        case ($urandom_range(0, 9))
            0:       u = t_unit'(CH_LT);
            1:       u = t_unit'(CH_SLASH);
            2:       u = t_unit'(CH_GT);
            3:       u = vary_case(letters[$urandom_range(0, letters.len() - 1)]);
            4:       u = ($urandom_range(0, 1) == 0) ? UNIT_KELVIN : UNIT_LONG_S;
            5:       u = t_unit'($urandom);
            default: u = t_unit'($urandom_range(16'h20, 16'h7E));
        endcase
        return u;
    endfunction

    task automatic send_tag(input logic closing, input logic kind);
        string name;
        name = tag_name(kind);
        send_unit(t_unit'(CH_LT));
        if (closing) send_unit(t_unit'(CH_SLASH));
        for (int i = 0; i < name.len(); i++) send_unit(vary_case(name[i]));
        send_unit(t_unit'(CH_GT));
    endtask

    // A tag cut short, then broken off by other text or by the end of stream.
    task automatic send_partial(input logic closing, input logic kind);
        string name;
        int    cut;
        name = tag_name(kind);
        cut  = $urandom_range(0, name.len() - 1);
        send_unit(t_unit'(CH_LT));
        if (closing) send_unit(t_unit'(CH_SLASH));
        for (int i = 0; i < cut; i++) send_unit(vary_case(name[i]));
        if ($urandom_range(0, 3) == 0) begin
            send_eos();
        end else begin
            send_unit(filler_unit());
        end
    endtask

    // A well-formed block with random content around it. Sometimes the body
    // sees an end of stream, a close tag of the other kind, or is left open.
    task automatic send_block();
        logic kind;
        int   lead;
        int   body;
        kind = 1'($urandom_range(0, 1));
        lead = $urandom_range(0, 4);
        body = $urandom_range(0, 6);
        for (int i = 0; i < lead; i++) send_unit(filler_unit());
        send_tag(1'b0, kind);
        for (int i = 0; i < body; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_partial(1'b1, 1'($urandom_range(0, 1)));
            end else begin
                send_unit(filler_unit());
            end
        end
        if ($urandom_range(0, 5) == 0) send_eos();
        if ($urandom_range(0, 5) == 0) send_tag(1'b1, ~kind);
        if ($urandom_range(0, 7) != 0) send_tag(1'b1, kind);
    endtask

    initial begin
        int   start;
        int   pick;
        t_seg seg;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Extremes of the code unit pass straight through.
        send_unit(16'h0000);
        send_unit(16'hFFFF);
        // A held prefix of an open tag is released by the end of stream.
        send_text("<r");
        send_eos();
        // An open tag in mixed case with the Kelvin sign gives the indicator.
        send_text("<ThIN");
        send_unit(UNIT_KELVIN);
        send_text(">");
        // Inside the block, an end of stream discards the tail and leaves the
        // block open; the close tag then ends it.
        send_text("<");
        send_eos();
        send_text("</thinK>");
        // The long s folds while matching but is released unchanged once the
        // prefix breaks.
        send_text("<REA");
        send_unit(UNIT_LONG_S);
        send_text("Z");

        // Random part, mostly well-formed blocks.
        start = sent;
        while (sent - start < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                seg = SEG_BLOCK;
            end else if (pick < 70) begin
                seg = SEG_TEXT;
            end else if (pick < 82) begin
                seg = SEG_PARTIAL;
            end else if (pick < 92) begin
                seg = SEG_NOISE;
            end else begin
                seg = SEG_FLUSH;
            end
            case (seg)
                SEG_BLOCK: begin
                    send_block();
                end
                SEG_TEXT: begin
                    repeat ($urandom_range(1, 6)) send_unit(filler_unit());
                end
                SEG_PARTIAL: begin
                    send_partial(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                SEG_NOISE: begin
                    repeat ($urandom_range(1, 4)) send_unit(t_unit'($urandom));
                end
                default: begin
                    send_eos();
                end
            endcase
        end
        in_valid <= 1'b0;

        // The checker's pending count is registered, so it lags behind the last accepted word.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
